@@ rtl/core/ate_pkg.sv @@
// Package for the adaptive timeout estimator: window sizing, register indexes,
// queue item and configuration types. No dependencies.
`default_nettype none

package ate_pkg;

    localparam int WINDOW_DEPTH = 100;
    localparam int LAT_W        = 24;
    localparam int GAIN_W       = 8;
    localparam int FRAC_W       = 4;
    localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = LAT_W + CNT_W;
    localparam int STEP_W       = $clog2(SUM_W + 1);
    localparam int PROD_W       = LAT_W + GAIN_W;
    // queue pointers wrap naturally, so keep the depth a power of two
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int REG_IDX_W    = 3;

    localparam logic [LAT_W-1:0]  CONNECT_RESET = LAT_W'(5000);
    localparam logic [LAT_W-1:0]  SEND_RESET    = LAT_W'(30000);
    localparam logic [LAT_W-1:0]  RECEIVE_RESET = LAT_W'(30000);
    localparam logic [LAT_W-1:0]  OVERALL_RESET = LAT_W'(60000);
    localparam logic [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(48);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CONNECT = 3'd0,
        REG_SEND    = 3'd1,
        REG_RECEIVE = 3'd2,
        REG_OVERALL = 3'd3,
        REG_ADAPT   = 3'd4,
        REG_GAIN    = 3'd5
    } ate_reg_t;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } ate_op_t;

    typedef enum logic [1:0] {
        PH_CONNECT = 2'd0,
        PH_SEND    = 2'd1,
        PH_RECEIVE = 2'd2,
        PH_TOTAL   = 2'd3
    } ate_phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EVICT,
        BK_DIV,
        BK_MUL,
        BK_CLAMP
    } ate_state_t;

    typedef struct packed {
        ate_op_t          op;
        ate_phase_t       phase;
        logic [LAT_W-1:0] latency;
        logic             succeeded;
    } ate_item_t;

    typedef struct packed {
        logic [LAT_W-1:0]  connect_limit;
        logic [LAT_W-1:0]  send_limit;
        logic [LAT_W-1:0]  receive_limit;
        logic [LAT_W-1:0]  overall_limit;
        logic              adapt_enable;
        logic [GAIN_W-1:0] gain_q4;
    } ate_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/ate_front.sv @@
// Front end: accepts stream items, classifies them into record or query
// items and holds one until the queue takes it. Uses ate_pkg.
`default_nettype none

module ate_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,  // latency_ms[23:0], succeeded[24], zero pad
    input  wire logic [2:0]        s_axis_tuser,  // command[0], phase_sel[2:1]
    output logic                   push_valid,
    input  wire logic              push_ready,
    output ate_pkg::ate_item_t     push_item
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    ate_pkg::ate_item_t hold_item_reg;
    ate_pkg::ate_item_t in_item;
    logic               take;

    always_comb
    begin
        in_item.op        = s_axis_tuser[0] ? ate_pkg::OP_QUERY : ate_pkg::OP_RECORD;
        in_item.phase     = ate_pkg::ate_phase_t'(s_axis_tuser[2:1]);
        in_item.latency   = s_axis_tdata[ate_pkg::LAT_W-1:0];
        in_item.succeeded = s_axis_tdata[ate_pkg::LAT_W];
    end

    assign s_axis_tready = !hold_valid_reg || push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign push_valid    = hold_valid_reg;
    assign push_item     = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ate_queue.sv @@
// Short item queue between front and back end, so each side stalls on its own.
// Uses ate_pkg.
`default_nettype none

module ate_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire ate_pkg::ate_item_t push_item,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output ate_pkg::ate_item_t      pop_item
);

    ate_pkg::ate_item_t               slot_reg [ate_pkg::QUEUE_DEPTH];
    logic [ate_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ate_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [ate_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ate_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [ate_pkg::QCNT_W-1:0]       count_reg;
    logic [ate_pkg::QCNT_W-1:0]       count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = count_reg != ate_pkg::QCNT_W'(ate_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ate_back.sv @@
// Back end: latency window ring, running success sum and count, serial mean
// divider, gain multiply and clamp, output register. Uses ate_pkg.
`default_nettype none

module ate_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ate_pkg::ate_cfg_t  cfg,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire ate_pkg::ate_item_t pop_item,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [47:0]             m_axis_tdata   // timeout_ms[23:0], mean_latency[47:24]
);

    localparam int LAT_W  = ate_pkg::LAT_W;
    localparam int PTR_W  = ate_pkg::PTR_W;
    localparam int CNT_W  = ate_pkg::CNT_W;
    localparam int SUM_W  = ate_pkg::SUM_W;
    localparam int STEP_W = ate_pkg::STEP_W;
    localparam int PROD_W = ate_pkg::PROD_W;
    localparam int ADP_W  = PROD_W - ate_pkg::FRAC_W;

    // window storage
    logic [LAT_W-1:0] lat_mem  [ate_pkg::WINDOW_DEPTH];
    logic             succ_mem [ate_pkg::WINDOW_DEPTH];
    logic [LAT_W-1:0] rd_lat_reg;
    logic             rd_succ_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;

    ate_pkg::ate_state_t state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [PTR_W-1:0]    oldest_reg, oldest_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    scount_reg, scount_next;
    logic                out_valid_reg, out_valid_next;

    logic [LAT_W-1:0]    cur_lat_reg, cur_lat_next;
    logic                cur_ok_reg, cur_ok_next;
    logic [LAT_W-1:0]    base_reg, base_next;
    logic [SUM_W-1:0]    div_reg, div_next;
    logic [CNT_W:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [LAT_W-1:0]    mean_reg, mean_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [LAT_W-1:0]    out_timeout_reg, out_timeout_next;
    logic [LAT_W-1:0]    out_mean_reg, out_mean_next;

    logic [LAT_W-1:0]    phase_base;
    logic [CNT_W:0]      slot_sum;
    logic [PTR_W-1:0]    append_slot;
    logic [PTR_W-1:0]    oldest_inc;
    logic                window_full;
    logic [CNT_W:0]      rem_shift;
    logic [ADP_W-1:0]    adaptive;
    logic [LAT_W-1:0]    half_base;
    logic [LAT_W-1:0]    clamped;
    logic                out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_mean_reg, out_timeout_reg};
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pop_ready     = state_reg == ate_pkg::BK_IDLE;
    assign window_full   = fill_reg == CNT_W'(ate_pkg::WINDOW_DEPTH);

    always_comb
    begin
        unique case (pop_item.phase)
            ate_pkg::PH_CONNECT: phase_base = cfg.connect_limit;
            ate_pkg::PH_SEND:    phase_base = cfg.send_limit;
            ate_pkg::PH_RECEIVE: phase_base = cfg.receive_limit;
            ate_pkg::PH_TOTAL:   phase_base = cfg.overall_limit;
            default:             phase_base = cfg.overall_limit;
        endcase
    end

    // ring slot arithmetic: oldest stays below the depth, fill at most reaches it
    always_comb
    begin
        slot_sum = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(fill_reg);
        if (slot_sum >= (CNT_W+1)'(ate_pkg::WINDOW_DEPTH))
        begin
            slot_sum = slot_sum - (CNT_W+1)'(ate_pkg::WINDOW_DEPTH);
        end
        append_slot = slot_sum[PTR_W-1:0];
        if (oldest_reg == PTR_W'(ate_pkg::WINDOW_DEPTH - 1))
        begin
            oldest_inc = '0;
        end
        else
        begin
            oldest_inc = oldest_reg + 1'b1;
        end
    end

    always_comb
    begin
        rem_shift = {rem_reg[CNT_W-1:0], div_reg[SUM_W-1]};
        adaptive  = prod_reg[PROD_W-1:ate_pkg::FRAC_W];
        half_base = base_reg >> 1;
        if (adaptive < ADP_W'(base_reg))
        begin
            clamped = adaptive[LAT_W-1:0];
        end
        else
        begin
            clamped = base_reg;
        end
        if (clamped < half_base)
        begin
            clamped = half_base;
        end
        if (!cfg.adapt_enable || fill_reg == '0)
        begin
            clamped = base_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        oldest_next      = oldest_reg;
        sum_next         = sum_reg;
        scount_next      = scount_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        cur_lat_next     = cur_lat_reg;
        cur_ok_next      = cur_ok_reg;
        base_next        = base_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        mean_next        = mean_reg;
        prod_next        = prod_reg;
        out_timeout_next = out_timeout_reg;
        out_mean_next    = out_mean_reg;
        mem_we           = 1'b0;
        mem_waddr        = append_slot;

        unique case (state_reg)
            ate_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_lat_next = pop_item.latency;
                    cur_ok_next  = pop_item.succeeded;
                    base_next    = phase_base;
                    if (pop_item.op == ate_pkg::OP_RECORD)
                    begin
                        if (window_full)
                        begin
                            // oldest entry is being read this cycle
                            state_next = ate_pkg::BK_EVICT;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                            if (pop_item.succeeded)
                            begin
                                sum_next    = sum_reg + SUM_W'(pop_item.latency);
                                scount_next = scount_reg + 1'b1;
                            end
                        end
                    end
                    else if (scount_reg == '0)
                    begin
                        mean_next  = '0;
                        state_next = ate_pkg::BK_MUL;
                    end
                    else
                    begin
                        div_next   = sum_reg;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ate_pkg::BK_DIV;
                    end
                end
            end
            ate_pkg::BK_EVICT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = oldest_reg;
                oldest_next = oldest_inc;
                sum_next    = sum_reg - (rd_succ_reg ? SUM_W'(rd_lat_reg) : '0)
                            + (cur_ok_reg ? SUM_W'(cur_lat_reg) : '0);
                scount_next = scount_reg - CNT_W'(rd_succ_reg) + CNT_W'(cur_ok_reg);
                state_next  = ate_pkg::BK_IDLE;
            end
            ate_pkg::BK_DIV:
            begin
                // one restoring step per cycle
                if (rem_shift >= {1'b0, scount_reg})
                begin
                    rem_next = rem_shift - {1'b0, scount_reg};
                    div_next = {div_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    div_next = {div_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    mean_next  = div_next[LAT_W-1:0];
                    state_next = ate_pkg::BK_MUL;
                end
            end
            ate_pkg::BK_MUL:
            begin
                prod_next  = PROD_W'(mean_reg) * PROD_W'(cfg.gain_q4);
                state_next = ate_pkg::BK_CLAMP;
            end
            ate_pkg::BK_CLAMP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_timeout_next = clamped;
                    out_mean_next    = mean_reg;
                    state_next       = ate_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ate_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ate_pkg::BK_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            sum_reg       <= '0;
            scount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            sum_reg       <= sum_next;
            scount_reg    <= scount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_lat_reg     <= cur_lat_next;
        cur_ok_reg      <= cur_ok_next;
        base_reg        <= base_next;
        div_reg         <= div_next;
        rem_reg         <= rem_next;
        step_reg        <= step_next;
        mean_reg        <= mean_next;
        prod_reg        <= prod_next;
        out_timeout_reg <= out_timeout_next;
        out_mean_reg    <= out_mean_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lat_mem[mem_waddr]  <= cur_lat_next;
            succ_mem[mem_waddr] <= cur_ok_next;
        end
        rd_lat_reg  <= lat_mem[oldest_reg];
        rd_succ_reg <= succ_mem[oldest_reg];
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ate_pkg::WINDOW_DEPTH))
        else $error("window fill count beyond depth");

    a_scount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scount_reg <= fill_reg)
        else $error("success count exceeds fill count");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        scount_reg == '0 |-> sum_reg == '0)
        else $error("nonzero success sum with no successes");

    a_evict_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ate_pkg::BK_EVICT |-> $past(state_reg) == ate_pkg::BK_IDLE
            && $past(window_full))
        else $error("eviction without a full window");
`endif

endmodule

`default_nettype wire

@@ rtl/core/adaptive_timeout_estimator_core.sv @@
// Adaptive timeout estimator, top level: configuration registers, front end,
// item queue and back end. Uses ate_pkg, ate_front, ate_queue and ate_back.
// A record item updates the window from the back end's idle state, or by way of
// an evict state when the window is full and the oldest entry is read first; a
// query result comes from the 31-step serial divider for the mean, then one
// multiply and one clamp step, with the divider skipped when the window holds no
// successful record. The back end takes no new item until it is back in idle;
// the front end and queue keep accepting items meanwhile while the queue has room.
// Reset: limits, adapt enable and gain return to their defaults and the window
// is empty; ring contents are not cleared and their reads are never used before written.
`default_nettype none

module adaptive_timeout_estimator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ate_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [ate_pkg::LAT_W-1:0]     cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // latency_ms[23:0], succeeded[24]
    input  wire logic [2:0]                    s_axis_tuser,  // command[0], phase_sel[2:1]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [47:0]                        m_axis_tdata   // timeout_ms[23:0], mean_latency[47:24]
);

    ate_pkg::ate_cfg_t  cfg_reg;
    ate_pkg::ate_cfg_t  cfg_next;
    logic               push_valid;
    logic               push_ready;
    ate_pkg::ate_item_t push_item;
    logic               pop_valid;
    logic               pop_ready;
    ate_pkg::ate_item_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ate_pkg::REG_CONNECT: cfg_next.connect_limit = cfg_data;
                ate_pkg::REG_SEND:    cfg_next.send_limit    = cfg_data;
                ate_pkg::REG_RECEIVE: cfg_next.receive_limit = cfg_data;
                ate_pkg::REG_OVERALL: cfg_next.overall_limit = cfg_data;
                ate_pkg::REG_ADAPT:   cfg_next.adapt_enable  = cfg_data[0];
                ate_pkg::REG_GAIN:    cfg_next.gain_q4       = cfg_data[ate_pkg::GAIN_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.connect_limit <= ate_pkg::CONNECT_RESET;
            cfg_reg.send_limit    <= ate_pkg::SEND_RESET;
            cfg_reg.receive_limit <= ate_pkg::RECEIVE_RESET;
            cfg_reg.overall_limit <= ate_pkg::OVERALL_RESET;
            cfg_reg.adapt_enable  <= 1'b1;
            cfg_reg.gain_q4       <= ate_pkg::GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ate_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    ate_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ate_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
